### src/ofhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ofhp_pkg;

   localparam int OFFSET_BITS_DEFAULT = 25;

   localparam int MIN_FIRST_LEN = 13;
   localparam int HDR_END_LEN   = 17;
   localparam int SI_MIN_LEN    = 34;
   localparam int LATER_MIN_LEN = 4;
   localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TOO_SHORT = 3'd1,
      ST_BAD_SIG   = 3'd2,
      ST_BAD_VER   = 3'd3,
      ST_NOT_SI    = 3'd4,
      ST_TRUNCATED = 3'd5,
      ST_SI_SHORT  = 3'd6,
      ST_ZERO_RATE = 3'd7
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       packet_end;
   } req_item_type;

   typedef struct packed {
      logic        accepted;
      status_type  status;
      logic [6:0]  block_kind;
      logic        last_block_flag;
      logic [19:0] stream_rate;
      logic [3:0]  channel_count;
      logic [15:0] expected_count;
      logic [16:0] packets_seen;
      logic        headers_complete;
   } rsp_item_type;

   // 0x7F "FLAC"
   function automatic logic [7:0] lead_byte(input logic [2:0] idx);
      logic [7:0] val;
      unique case (idx)
         3'd0:    val = 8'h7F;
         3'd1:    val = 8'h46;
         3'd2:    val = 8'h4C;
         3'd3:    val = 8'h41;
         3'd4:    val = 8'h43;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   // "fLaC"
   function automatic logic [7:0] mark_byte(input logic [1:0] idx);
      logic [7:0] val;
      unique case (idx)
         2'd0: val = 8'h66;
         2'd1: val = 8'h4C;
         2'd2: val = 8'h61;
         2'd3: val = 8'h43;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

### src/ogg_flac_header_packet_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Ogg FLAC header packet parser. Feed header packet bytes in order, one per request, with
// packet_end set on each packet's last byte; one result per packet is registered as that
// byte leaves the input register. The first packet must be the Ogg FLAC mapping header
// with a valid STREAMINFO block; later packets are counted as metadata blocks. Throughput
// is one byte per clock: each byte passes an input register, a single pass of compare
// and capture logic against the parser state, and a result register that holds a pending
// result while the next bytes keep flowing. Bytes that do not end a packet never wait
// on the result side; a packet's last byte waits only while a previous result is stalled.
module ogg_flac_header_packet_parser_top #(
   parameter int OFFSET_BITS = ofhp_pkg::OFFSET_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire ofhp_pkg::req_item_type req_data,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output ofhp_pkg::rsp_item_type      rsp_data
);
   import ofhp_pkg::*;

   logic         item_valid, advance, out_free, fire;
   req_item_type item_data;
   rsp_item_type result;

   // advance a byte unless it closes a packet and the result slot is still full
   assign advance = item_valid && (!item_data.packet_end || out_free);
   assign fire    = advance;

   ofhp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .advance    (advance),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   ofhp_parse #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item_data (item_data),
      .result    (result)
   );

   ofhp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && item_data.packet_end),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

### src/ofhp_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module ofhp_in_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire ofhp_pkg::req_item_type req_data,
   output logic                       req_stall,
   input  wire logic                  advance,
   output logic                       item_valid,
   output ofhp_pkg::req_item_type     item_data
);
   import ofhp_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type data_ff;

   assign req_stall  = valid_ff && !advance;
   assign item_valid = valid_ff;
   assign item_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (!req_stall) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         data_ff <= req_data;
      end
   end

endmodule
`default_nettype wire

### src/ofhp_parse.sv
`timescale 1ns / 1ps
`default_nettype none
module ofhp_parse #(
   parameter int OFFSET_BITS = ofhp_pkg::OFFSET_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire ofhp_pkg::req_item_type item_data,
   output ofhp_pkg::rsp_item_type      result
);
   import ofhp_pkg::*;

   localparam int LEN_W = (OFFSET_BITS + 1 > 26) ? OFFSET_BITS + 1 : 26;

   // per-packet state
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic        sig_ok_ff, sig_ok_in;
   logic        ver_ok_ff, ver_ok_in;
   logic        mark_ok_ff, mark_ok_in;
   logic [7:0]  hdr_ff, hdr_in;
   logic [23:0] body_ff, body_in;
   logic [23:0] rate_sh_ff, rate_sh_in;
   logic [15:0] pend_ff, pend_in;
   // stream state
   logic [15:0] announced_ff, announced_in;
   logic [16:0] count_ff, count_in;
   logic        final_ff, final_in;
   logic        si_seen_ff, si_seen_in;
   logic [19:0] held_rate_ff, held_rate_in;
   logic [3:0]  held_chan_ff, held_chan_in;

   logic [OFFSET_BITS-1:0] offset_n;
   logic        sig_n, ver_n, mark_n;
   logic [7:0]  hdr_n, b;
   logic [23:0] body_n, rate_n;
   logic [15:0] pend_n;
   logic [LEN_W-1:0] pos, len;
   logic        first, accepted, complete;
   status_type  status;

   always_comb begin
      b     = item_data.data_byte;
      pos   = LEN_W'(offset_ff);
      len   = pos + LEN_W'(1);
      first = (count_ff == '0);

      sig_n    = sig_ok_ff;
      ver_n    = ver_ok_ff;
      mark_n   = mark_ok_ff;
      hdr_n    = hdr_ff;
      body_n   = body_ff;
      rate_n   = rate_sh_ff;
      pend_n   = pend_ff;
      offset_n = (&offset_ff) ? offset_ff : offset_ff + 1'b1;

      if (first) begin
         if (pos < LEN_W'(5)) begin
            if (b != lead_byte(offset_ff[2:0])) sig_n = 1'b0;
         end else if (pos == LEN_W'(5)) begin
            ver_n = (b == 8'd1);
         end else if (pos == LEN_W'(7)) begin
            pend_n = {b, 8'h00};
         end else if (pos == LEN_W'(8)) begin
            pend_n = {pend_ff[15:8], b};
         end else if (pos >= LEN_W'(9) && pos <= LEN_W'(12)) begin
            // offsets 9..12 map to marker index 0..3
            if (b != mark_byte(offset_ff[1:0] - 2'd1)) mark_n = 1'b0;
         end else if (pos == LEN_W'(13)) begin
            hdr_n = b;
         end else if (pos >= LEN_W'(14) && pos <= LEN_W'(16)) begin
            body_n = {body_ff[15:0], b};
         end else if (pos >= LEN_W'(27) && pos <= LEN_W'(29)) begin
            rate_n = {rate_sh_ff[15:0], b};
         end
      end else if (pos == '0) begin
         hdr_n = b;
      end

      announced_in = announced_ff;
      count_in     = count_ff;
      final_in     = final_ff;
      si_seen_in   = si_seen_ff;
      held_rate_in = held_rate_ff;
      held_chan_in = held_chan_ff;
      status       = ST_OK;
      accepted     = 1'b0;

      if (first) begin
         priority if (len < LEN_W'(MIN_FIRST_LEN)) begin
            status = ST_TOO_SHORT;
         end else if (!sig_n) begin
            status = ST_BAD_SIG;
         end else if (!ver_n) begin
            status = ST_BAD_VER;
         end else begin
            announced_in = pend_n;
            priority if (!mark_n) begin
               status = ST_BAD_SIG;
            end else if (len < LEN_W'(HDR_END_LEN)) begin
               status = ST_TOO_SHORT;
            end else begin
               if (hdr_n[7]) final_in = 1'b1;
               priority if (hdr_n[6:0] != 7'd0) begin
                  status = ST_NOT_SI;
               end else if (len < LEN_W'(HDR_END_LEN) + LEN_W'(body_n)) begin
                  status = ST_TRUNCATED;
               end else if (body_n < 24'(SI_MIN_LEN)) begin
                  status = ST_SI_SHORT;
               end else begin
                  held_rate_in = rate_n[23:4];
                  if (rate_n[23:4] == 20'd0) begin
                     status = ST_ZERO_RATE;
                  end else begin
                     held_chan_in = {1'b0, rate_n[3:1]} + 4'd1;
                     si_seen_in   = 1'b1;
                     count_in     = 17'd1;
                     accepted     = 1'b1;
                  end
               end
            end
         end
      end else begin
         if (len < LEN_W'(LATER_MIN_LEN)) begin
            status = ST_TOO_SHORT;
         end else begin
            if (hdr_n[7]) final_in = 1'b1;
            if (count_ff != COUNT_MAX) count_in = count_ff + 17'd1;
            accepted = 1'b1;
         end
      end

      priority if (!si_seen_in) begin
         complete = 1'b0;
      end else if (announced_in != 16'd0) begin
         complete = count_in > {1'b0, announced_in};
      end else begin
         complete = final_in;
      end

      result.accepted         = accepted;
      result.status           = status;
      result.block_kind       = hdr_n[6:0];
      result.last_block_flag  = hdr_n[7];
      result.stream_rate      = held_rate_in;
      result.channel_count    = held_chan_in;
      result.expected_count   = announced_in;
      result.packets_seen     = count_in;
      result.headers_complete = complete;

      // default: hold everything
      offset_in   = offset_ff;
      sig_ok_in   = sig_ok_ff;
      ver_ok_in   = ver_ok_ff;
      mark_ok_in  = mark_ok_ff;
      hdr_in      = hdr_ff;
      body_in     = body_ff;
      rate_sh_in  = rate_sh_ff;
      pend_in     = pend_ff;
      if (fire) begin
         if (item_data.packet_end) begin
            offset_in  = '0;
            sig_ok_in  = 1'b1;
            ver_ok_in  = 1'b0;
            mark_ok_in = 1'b1;
            hdr_in     = 8'd0;
            body_in    = 24'd0;
            rate_sh_in = 24'd0;
            pend_in    = 16'd0;
         end else begin
            offset_in  = offset_n;
            sig_ok_in  = sig_n;
            ver_ok_in  = ver_n;
            mark_ok_in = mark_n;
            hdr_in     = hdr_n;
            body_in    = body_n;
            rate_sh_in = rate_n;
            pend_in    = pend_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         sig_ok_ff    <= 1'b1;
         ver_ok_ff    <= 1'b0;
         mark_ok_ff   <= 1'b1;
         hdr_ff       <= 8'd0;
         body_ff      <= 24'd0;
         rate_sh_ff   <= 24'd0;
         pend_ff      <= 16'd0;
         announced_ff <= 16'd0;
         count_ff     <= 17'd0;
         final_ff     <= 1'b0;
         si_seen_ff   <= 1'b0;
         held_rate_ff <= 20'd0;
         held_chan_ff <= 4'd0;
      end else begin
         offset_ff  <= offset_in;
         sig_ok_ff  <= sig_ok_in;
         ver_ok_ff  <= ver_ok_in;
         mark_ok_ff <= mark_ok_in;
         hdr_ff     <= hdr_in;
         body_ff    <= body_in;
         rate_sh_ff <= rate_sh_in;
         pend_ff    <= pend_in;
         // stream state moves only at a packet's last byte
         if (fire && item_data.packet_end) begin
            announced_ff <= announced_in;
            count_ff     <= count_in;
            final_ff     <= final_in;
            si_seen_ff   <= si_seen_in;
            held_rate_ff <= held_rate_in;
            held_chan_ff <= held_chan_in;
         end
      end
   end

endmodule
`default_nettype wire

### src/ofhp_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module ofhp_out_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire ofhp_pkg::rsp_item_type result,
   output logic                        out_free,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output ofhp_pkg::rsp_item_type      rsp_data
);
   import ofhp_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type data_ff;

   assign out_free  = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
   import ofhp_pkg::*;

   localparam int OFF_W = OFFSET_BITS_DEFAULT;
   localparam int RAND_HEADER_ITEMS = 450;
   localparam int RAND_ITEMS = 650;
   localparam int MAX_REPORTS = 10;
   localparam logic [39:0] SIG_SEQ = 40'h7F_46_4C_41_43;
   localparam logic [31:0] MARK_SEQ = 32'h66_4C_61_43;

   typedef enum int {
      PACE_FULL,
      PACE_SEND_GAPS,
      PACE_RECV_STALLS,
      PACE_BOTH
   } pace_type;

   typedef enum int {
      FLAW_SHORT,
      FLAW_SIG,
      FLAW_VER,
      FLAW_MARK,
      FLAW_NO_BODY,
      FLAW_NOT_SI,
      FLAW_TRUNC,
      FLAW_SI_SHORT,
      FLAW_ZERO_RATE,
      FLAW_NOISE
   } flaw_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   req_item_type req_data = '0;
   logic         req_stall;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   // parser state as predicted
   logic [OFF_W-1:0] off_r;
   logic             sig_good;
   logic             ver_good;
   logic             mark_good;
   logic [7:0]       blk_hdr;
   logic [23:0]      blk_len;
   logic [23:0]      rate_shift;
   logic [15:0]      count_shift;
   logic [15:0]      announced;
   logic [16:0]      taken_count;
   logic             final_seen;
   logic             si_seen;
   logic [19:0]      rate_hold;
   logic [3:0]       chan_hold;

   rsp_item_type pending_verdicts[$];
   rsp_item_type want;
   logic [7:0]   packet[$];

   int         idle_pct = 0;
   int         stall_pct = 0;
   int         mismatch_n = 0;
   int         sent_n = 0;
   int         results_n = 0;
   int         taken_n = 0;
   int         rand_n = 0;
   int         pkt_n = 0;
   logic [7:0] status_hits = '0;

   always #5 clock = ~clock;

   ogg_flac_header_packet_parser_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
   end

   task automatic clear_packet_state();
      off_r = '0;
      sig_good = 1'b1;
      ver_good = 1'b0;
      mark_good = 1'b1;
      blk_hdr = '0;
      blk_len = '0;
      rate_shift = '0;
      count_shift = '0;
   endtask

   task automatic reset_model();
      clear_packet_state();
      announced = '0;
      taken_count = '0;
      final_seen = 1'b0;
      si_seen = 1'b0;
      rate_hold = '0;
      chan_hold = '0;
   endtask

   // advance the parser by one byte; queue the verdict on a packet's last byte
   task automatic predict_packet_byte(input logic [7:0] b, input logic last);
      int           p;
      int           len;
      status_type   st;
      logic         took;
      logic         done;
      rsp_item_type r;
      p = int'(off_r);
      st = ST_OK;
      took = 1'b0;
      if (taken_count == '0) begin
         if (p < 5) begin
            if (b != SIG_SEQ[39 - 8*p -: 8]) sig_good = 1'b0;
         end else if (p == 5) begin
            ver_good = (b == 8'd1);
         end else if (p == 7) begin
            count_shift = {b, 8'h00};
         end else if (p == 8) begin
            count_shift[7:0] = b;
         end else if (p >= 9 && p <= 12) begin
            if (b != MARK_SEQ[31 - 8*(p-9) -: 8]) mark_good = 1'b0;
         end else if (p == 13) begin
            blk_hdr = b;
         end else if (p >= 14 && p <= 16) begin
            blk_len = {blk_len[15:0], b};
         end else if (p >= 27 && p <= 29) begin
            rate_shift = {rate_shift[15:0], b};
         end
      end else if (p == 0) begin
         blk_hdr = b;
      end
      if (off_r != '1) off_r = off_r + 1'b1;
      if (!last) return;

      len = p + 1;
      if (taken_count == '0) begin
         if (len < MIN_FIRST_LEN) st = ST_TOO_SHORT;
         else if (!sig_good) st = ST_BAD_SIG;
         else if (!ver_good) st = ST_BAD_VER;
         else begin
            // count latches even if the rest of the header is rejected
            announced = count_shift;
            if (!mark_good) st = ST_BAD_SIG;
            else if (len < HDR_END_LEN) st = ST_TOO_SHORT;
            else begin
               if (blk_hdr[7]) final_seen = 1'b1;
               if (blk_hdr[6:0] != 7'd0) st = ST_NOT_SI;
               else if (len < HDR_END_LEN + int'(blk_len)) st = ST_TRUNCATED;
               else if (blk_len < SI_MIN_LEN) st = ST_SI_SHORT;
               else begin
                  rate_hold = rate_shift[23:4];
                  if (rate_hold == '0) st = ST_ZERO_RATE;
                  else begin
                     chan_hold = {1'b0, rate_shift[3:1]} + 4'd1;
                     si_seen = 1'b1;
                     taken_count = 17'd1;
                     took = 1'b1;
                  end
               end
            end
         end
      end else if (len < LATER_MIN_LEN) begin
         st = ST_TOO_SHORT;
      end else begin
         if (blk_hdr[7]) final_seen = 1'b1;
         if (taken_count != COUNT_MAX) taken_count = taken_count + 1'b1;
         took = 1'b1;
      end

      if (!si_seen) done = 1'b0;
      else if (announced != '0) done = (taken_count > {1'b0, announced});
      else done = final_seen;

      r.accepted = took;
      r.status = st;
      r.block_kind = blk_hdr[6:0];
      r.last_block_flag = blk_hdr[7];
      r.stream_rate = rate_hold;
      r.channel_count = chan_hold;
      r.expected_count = announced;
      r.packets_seen = taken_count;
      r.headers_complete = done;
      pending_verdicts.insert(pending_verdicts.size(), r);
      clear_packet_state();
   endtask

   function automatic string verdict_text(input rsp_item_type r);
      return $sformatf("acc=%0b st=%0d kind=%02h last=%0b rate=%0d ch=%0d exp=%0d seen=%0d done=%0b",
                       r.accepted, r.status, r.block_kind, r.last_block_flag, r.stream_rate,
                       r.channel_count, r.expected_count, r.packets_seen, r.headers_complete);
   endfunction

   // rsp_stall and rsp_data are stable from here to the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_n++;
         status_hits[rsp_data.status] = 1'b1;
         if (rsp_data.accepted) taken_n++;
         if (pending_verdicts.size() == 0) begin
            mismatch_n++;
            if (mismatch_n <= MAX_REPORTS)
               $display("%0t: result with no packet pending: %s", $realtime,
                        verdict_text(rsp_data));
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_data !== want) begin
               mismatch_n++;
               if (mismatch_n <= MAX_REPORTS) begin
                  $display("%0t: packet result differs", $realtime);
                  $display("   expected %s", verdict_text(want));
                  $display("   actual   %s", verdict_text(rsp_data));
               end
            end
         end
      end
   end

   task automatic set_pace(input pace_type m);
      case (m)
         PACE_FULL: begin
            idle_pct = 0;
            stall_pct = 0;
         end
         PACE_SEND_GAPS: begin
            idle_pct = 46;
            stall_pct = 0;
         end
         PACE_RECV_STALLS: begin
            idle_pct = 0;
            stall_pct = 46;
         end
         default: begin
            idle_pct = 20;
            stall_pct = 20;
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      logic held;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= {b, last};
      do begin
         @(negedge clock);
         held = req_stall;
         @(posedge clock);
      end while (held);
      predict_packet_byte(b, last);
      sent_n++;
   endtask

   task automatic send_packet();
      for (int i = 0; i < packet.size(); i++) begin
         send_byte(packet[i], i == packet.size() - 1);
      end
   endtask

   // hold the sender off until every packet result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic build_header_packet(input logic [15:0] cnt, input logic [7:0] hdr,
                                      input logic [23:0] blen, input logic [19:0] rate,
                                      input logic [2:0] chans, input int len);
      logic [23:0] rbits;
      rbits = {rate, chans, 1'($urandom_range(0, 1))};
      packet.delete();
      for (int i = 0; i < len; i++) begin
         packet.insert(packet.size(), 8'($urandom_range(0, 255)));
      end
      for (int i = 0; i < len && i < 30; i++) begin
         if (i < 5) packet[i] = SIG_SEQ[39 - 8*i -: 8];
         else if (i == 5) packet[i] = 8'd1;
         else if (i == 7) packet[i] = cnt[15:8];
         else if (i == 8) packet[i] = cnt[7:0];
         else if (i >= 9 && i <= 12) packet[i] = MARK_SEQ[31 - 8*(i-9) -: 8];
         else if (i == 13) packet[i] = hdr;
         else if (i >= 14 && i <= 16) packet[i] = blen[23 - 8*(i-14) -: 8];
         else if (i >= 27) packet[i] = rbits[23 - 8*(i-27) -: 8];
      end
   endtask

   task automatic flip_byte(input int k);
      packet[k] = packet[k] ^ 8'($urandom_range(1, 255));
   endtask

   // a mapping header with exactly one defect, or random bytes for FLAW_NOISE
   task automatic build_flawed_header(input flaw_type f, input logic extreme);
      int          len;
      logic [23:0] blen;
      logic [7:0]  hdr;
      logic [19:0] rate;
      logic [15:0] cnt;
      blen = extreme ? 24'd34 : 24'($urandom_range(34, 40));
      len = HDR_END_LEN + int'(blen);
      hdr = {1'($urandom_range(0, 1)), 7'd0};
      rate = extreme ? 20'hFFFFF : 20'($urandom_range(1, 20'hFFFFF));
      cnt = extreme ? 16'hFFFF : 16'($urandom);
      case (f)
         FLAW_SHORT: len = extreme ? MIN_FIRST_LEN - 1 : $urandom_range(1, MIN_FIRST_LEN - 1);
         FLAW_NO_BODY: len = extreme ? HDR_END_LEN - 1 : $urandom_range(13, 16);
         FLAW_NOT_SI: hdr = extreme ? 8'hFF : {hdr[7], 7'($urandom_range(1, 127))};
         FLAW_TRUNC: begin
            blen = extreme ? 24'hFFFFFF : 24'($urandom_range(51, 24'hFFFFFF));
            len = $urandom_range(17, 50);
         end
         FLAW_SI_SHORT: begin
            blen = extreme ? 24'd0 : 24'($urandom_range(0, 33));
            len = HDR_END_LEN + int'(blen) + $urandom_range(0, 15);
         end
         FLAW_ZERO_RATE: rate = '0;
         default: ;
      endcase
      build_header_packet(cnt, hdr, blen, rate, 3'($urandom), len);
      case (f)
         FLAW_SIG: flip_byte($urandom_range(0, 4));
         FLAW_VER: packet[5] = 8'($urandom_range(2, 256));
         FLAW_MARK: flip_byte($urandom_range(9, 12));
         FLAW_NOISE: begin
            packet.delete();
            repeat ($urandom_range(1, 40))
               packet.insert(packet.size(), 8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
   endtask

   task automatic build_block_packet(input logic [7:0] hdr, input int len);
      packet.delete();
      packet.insert(packet.size(), hdr);
      repeat (len - 1) packet.insert(packet.size(), 8'($urandom_range(0, 255)));
   endtask

   task automatic test_header_rejects();
      set_pace(PACE_FULL);
      for (int f = FLAW_SHORT; f <= FLAW_NOISE; f++) begin
         build_flawed_header(flaw_type'(f), 1'b1);
         send_packet();
      end
   endtask

   task automatic test_header_random();
      while (rand_n < RAND_HEADER_ITEMS) begin
         set_pace(pace_type'((pkt_n / 5) % 4));
         build_flawed_header(flaw_type'($urandom_range(FLAW_SHORT, FLAW_NOISE)), 1'b0);
         send_packet();
         rand_n += packet.size();
         pkt_n++;
      end
   endtask

   task automatic test_header_accept();
      logic [15:0] cnt;
      cnt = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'($urandom_range(1, 6));
      set_pace(PACE_RECV_STALLS);
      build_header_packet(cnt, 8'h00, 24'd34, 20'hFFFFF, 3'd7, HDR_END_LEN + SI_MIN_LEN);
      send_packet();
   endtask

   task automatic test_block_directed();
      set_pace(PACE_BOTH);
      build_block_packet(8'h7F, 1);
      send_packet();
      build_block_packet(8'hFF, LATER_MIN_LEN - 1);
      send_packet();
      build_block_packet(8'h7F, LATER_MIN_LEN);
      send_packet();
      build_block_packet(8'h01, 100);
      send_packet();
      for (int k = 0; k < 6; k++) begin
         build_block_packet(8'(k + 2), LATER_MIN_LEN);
         send_packet();
      end
      build_block_packet(8'h80, 5);
      send_packet();
   endtask

   task automatic test_block_random();
      int pick;
      int len;
      while (rand_n < RAND_ITEMS) begin
         set_pace(pace_type'((pkt_n / 6) % 4));
         pick = $urandom_range(0, 9);
         if (pick == 0) len = $urandom_range(1, LATER_MIN_LEN - 1);
         else if (pick == 1) len = $urandom_range(13, 60);
         else len = $urandom_range(LATER_MIN_LEN, 12);
         build_block_packet(8'($urandom_range(0, 255)), len);
         send_packet();
         rand_n += len;
         pkt_n++;
         if (pkt_n % 40 == 0) drain_results();
      end
   endtask

   initial begin
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_header_rejects();
      drain_results();
      test_header_random();
      drain_results();
      test_header_accept();
      test_block_directed();
      drain_results();
      test_block_random();
      drain_results();
      repeat (20) @(posedge clock);
      $display("sent %0d bytes, checked %0d packet results (%0d taken as headers)",
               sent_n, results_n, taken_n);
      $display("status codes returned (one bit per code): %b", status_hits);
      if (mismatch_n == 0 && pending_verdicts.size() == 0) begin
         $display("ogg_flac_header_packet_parser_top: match");
      end else begin
         $display("ogg_flac_header_packet_parser_top: mismatch");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("ogg_flac_header_packet_parser_top: mismatch");
      $finish;
   end

endmodule
